/* hw/rtl/hsvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and constants for the integer HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  // Hue regions, each spanning a sixth of the color circle.
  typedef enum logic [2:0] {
    HUE_RED_YEL = 3'd0,
    HUE_YEL_GRN = 3'd1,
    HUE_GRN_CYN = 3'd2,
    HUE_CYN_BLU = 3'd3,
    HUE_BLU_MAG = 3'd4,
    HUE_MAG_RED = 3'd5
  } region_t;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SATURATION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS = 2'd1;
  localparam int unsigned CFG_DATA_W = 8;

  // Reset values of the configuration registers.
  localparam logic [7:0] SATURATION_RESET = 8'd250;
  localparam logic [7:0] BRIGHTNESS_RESET = 8'd250;

  // Arithmetic constants.
  localparam logic [7:0] REGION_SPAN = 8'd43;
  localparam logic [7:0] REM_SCALE   = 8'd6;
  localparam logic [7:0] FULL_SCALE  = 8'd255;
  localparam int unsigned PROD_SHIFT = 8;

  // Current configuration.
  typedef struct packed {
    logic [7:0] saturation;
    logic [7:0] brightness;
  } cfg_t;

  // After the region split.
  typedef struct packed {
    region_t    region;
    logic [7:0] rem;
  } split_t;

  // After the first product stage.
  typedef struct packed {
    region_t    region;
    logic [7:0] sat_rem;
    logic [7:0] sat_inv;
    logic [7:0] p;
  } stage2_t;

  // After the second product stage.
  typedef struct packed {
    region_t    region;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
  } stage3_t;

endpackage

/* hw/rtl/hsvrgb_hue_if.sv */
// ----------------------------------------------------------------------------
// hsvrgb_hue_if
// Input channel carrying one hue per beat.
// ----------------------------------------------------------------------------
interface hsvrgb_hue_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;

  modport source (output valid, output hue, input ready);
  modport sink (input valid, input hue, output ready);
endinterface

/* hw/rtl/hsvrgb_rgb_if.sv */
// ----------------------------------------------------------------------------
// hsvrgb_rgb_if
// Output channel carrying one red, green, blue triple per beat.
// ----------------------------------------------------------------------------
interface hsvrgb_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

/* hw/rtl/hsv_to_rgb_integer_unit.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_integer_unit
// Converts a stream of 8-bit hues to 8-bit red, green and blue using the
// configured saturation and brightness.
//
//   channel   dir   beat contents
//   hue_ch    in    hue[7:0]
//   rgb_ch    out   red[7:0], green[7:0], blue[7:0]
//   wr_*      in    wr_index[1:0], wr_data[7:0] (0: saturation, 1: brightness)
//
// Four register stages: region split, first products, second products and
// channel placement. One hue is taken every cycle unless rgb_ch stalls.
// Reset (rst, synchronous) empties the pipeline and sets both registers to
// 250. A stall on rgb_ch backs up stage by stage; a stage holds its beat
// until the stage after it has room, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module hsv_to_rgb_integer_unit (
  input  logic                                clk,
  input  logic                                rst,
  hsvrgb_hue_if.sink                          hue_ch,
  hsvrgb_rgb_if.source                        rgb_ch,
  input  logic                                wr_en,
  input  logic [hsvrgb_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [7:0]                          wr_data
);
  import hsvrgb_pkg::*;

  cfg_t    cfg;
  split_t  split_data;
  logic    split_valid;
  logic    split_ready;
  stage3_t s3_data;
  logic    s3_valid;
  logic    s3_ready;
  logic    out_ready;
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;

  // Configuration registers.
  hsvrgb_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // Region split.
  hsvrgb_split u_split (
    .clk        (clk),
    .rst        (rst),
    .hue_ch     (hue_ch),
    .down_ready (split_ready),
    .down_valid (split_valid),
    .down_data  (split_data)
  );

  // Product stages.
  hsvrgb_prod u_prod (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .up_valid   (split_valid),
    .up_ready   (split_ready),
    .up_data    (split_data),
    .down_ready (s3_ready),
    .down_valid (s3_valid),
    .down_data  (s3_data)
  );

  // Place v, p, q and t on the channels by region; grey when unsaturated.
  always_comb begin
    red_next   = cfg.brightness;
    green_next = cfg.brightness;
    blue_next  = cfg.brightness;
    if (cfg.saturation != 8'd0) begin
      unique case (s3_data.region)
        HUE_RED_YEL: begin
          red_next   = cfg.brightness;
          green_next = s3_data.t;
          blue_next  = s3_data.p;
        end
        HUE_YEL_GRN: begin
          red_next   = s3_data.q;
          green_next = cfg.brightness;
          blue_next  = s3_data.p;
        end
        HUE_GRN_CYN: begin
          red_next   = s3_data.p;
          green_next = cfg.brightness;
          blue_next  = s3_data.t;
        end
        HUE_CYN_BLU: begin
          red_next   = s3_data.p;
          green_next = s3_data.q;
          blue_next  = cfg.brightness;
        end
        HUE_BLU_MAG: begin
          red_next   = s3_data.t;
          green_next = s3_data.p;
          blue_next  = cfg.brightness;
        end
        default: begin
          red_next   = cfg.brightness;
          green_next = s3_data.p;
          blue_next  = s3_data.q;
        end
      endcase
    end
  end

  // Output register.
  assign out_ready = !rgb_ch.valid || rgb_ch.ready;
  assign s3_ready  = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_ch.valid <= 1'b0;
    end else if (out_ready) begin
      rgb_ch.valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s3_valid) begin
      rgb_ch.red   <= red_next;
      rgb_ch.green <= green_next;
      rgb_ch.blue  <= blue_next;
    end
  end

endmodule

/* hw/rtl/hsvrgb_cfg.sv */
// ----------------------------------------------------------------------------
// hsvrgb_cfg
// Saturation and brightness registers behind a simple write port.
// ----------------------------------------------------------------------------
module hsvrgb_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [hsvrgb_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [hsvrgb_pkg::CFG_DATA_W-1:0]     wr_data,
  output hsvrgb_pkg::cfg_t                      cfg
);
  import hsvrgb_pkg::*;

  // Writes to indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.saturation <= SATURATION_RESET;
      cfg.brightness <= BRIGHTNESS_RESET;
    end else if (wr_en) begin
      if (wr_index == CFG_SATURATION) begin
        cfg.saturation <= wr_data[7:0];
      end else if (wr_index == CFG_BRIGHTNESS) begin
        cfg.brightness <= wr_data[7:0];
      end
    end
  end

endmodule

/* hw/rtl/hsvrgb_split.sv */
// ----------------------------------------------------------------------------
// hsvrgb_split
// First pipeline stage: splits the hue into a region and a scaled remainder.
// ----------------------------------------------------------------------------
module hsvrgb_split (
  input  logic                 clk,
  input  logic                 rst,
  hsvrgb_hue_if.sink           hue_ch,
  input  logic                 down_ready,
  output logic                 down_valid,
  output hsvrgb_pkg::split_t   down_data
);
  import hsvrgb_pkg::*;

  region_t    region;
  logic [7:0] base;
  logic [5:0] rem_raw;
  logic [7:0] rem_scaled;
  logic       stage_ready;

  // Division by the region span as a compare ladder on the region bounds.
  always_comb begin
    priority if (hue_ch.hue >= 8'(5 * REGION_SPAN)) begin
      region = HUE_MAG_RED;
    end else if (hue_ch.hue >= 8'(4 * REGION_SPAN)) begin
      region = HUE_BLU_MAG;
    end else if (hue_ch.hue >= 8'(3 * REGION_SPAN)) begin
      region = HUE_CYN_BLU;
    end else if (hue_ch.hue >= 8'(2 * REGION_SPAN)) begin
      region = HUE_GRN_CYN;
    end else if (hue_ch.hue >= REGION_SPAN) begin
      region = HUE_YEL_GRN;
    end else begin
      region = HUE_RED_YEL;
    end
  end

  // Remainder within the region (at most 42), scaled by six.
  always_comb begin
    base       = 8'({5'd0, region} * REGION_SPAN);
    rem_raw    = 6'(hue_ch.hue - base);
    rem_scaled = 8'({2'd0, rem_raw} * REM_SCALE);
  end

  assign stage_ready  = !down_valid || down_ready;
  assign hue_ch.ready = stage_ready;

  // Stage register with its valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (stage_ready) begin
      down_valid <= hue_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && hue_ch.valid) begin
      down_data.region <= region;
      down_data.rem    <= rem_scaled;
    end
  end

endmodule

/* hw/rtl/hsvrgb_prod.sv */
// ----------------------------------------------------------------------------
// hsvrgb_prod
// Second and third pipeline stages: the scaled products p, q and t.
// ----------------------------------------------------------------------------
module hsvrgb_prod (
  input  logic                 clk,
  input  logic                 rst,
  input  hsvrgb_pkg::cfg_t     cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  hsvrgb_pkg::split_t   up_data,
  input  logic                 down_ready,
  output logic                 down_valid,
  output hsvrgb_pkg::stage3_t  down_data
);
  import hsvrgb_pkg::*;

  stage2_t     s2_data;
  logic        s2_valid;
  logic        s2_ready;
  logic        s3_ready;
  logic [15:0] prod_sr;
  logic [15:0] prod_si;
  logic [15:0] prod_p;
  logic [15:0] prod_q;
  logic [15:0] prod_t;

  // First products: s*rem, s*(255-rem) and v*(255-s).
  always_comb begin
    prod_sr = {8'd0, cfg.saturation} * {8'd0, up_data.rem};
    prod_si = {8'd0, cfg.saturation} * {8'd0, 8'(FULL_SCALE - up_data.rem)};
    prod_p  = {8'd0, cfg.brightness} * {8'd0, 8'(FULL_SCALE - cfg.saturation)};
  end

  assign s2_ready = !s2_valid || s3_ready;
  assign up_ready = s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && up_valid) begin
      s2_data.region  <= up_data.region;
      s2_data.sat_rem <= prod_sr[PROD_SHIFT +: 8];
      s2_data.sat_inv <= prod_si[PROD_SHIFT +: 8];
      s2_data.p       <= prod_p[PROD_SHIFT +: 8];
    end
  end

  // Second products: v*(255-a) and v*(255-b).
  always_comb begin
    prod_q = {8'd0, cfg.brightness} * {8'd0, 8'(FULL_SCALE - s2_data.sat_rem)};
    prod_t = {8'd0, cfg.brightness} * {8'd0, 8'(FULL_SCALE - s2_data.sat_inv)};
  end

  assign s3_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (s3_ready) begin
      down_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      down_data.region <= s2_data.region;
      down_data.p      <= s2_data.p;
      down_data.q      <= prod_q[PROD_SHIFT +: 8];
      down_data.t      <= prod_t[PROD_SHIFT +: 8];
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer HSV to RGB converter. Hues are pushed
// through the input channel with random gaps. A scoreboard class converts each
// accepted hue with the saturation and brightness that are in force at the
// time, and compares every returned color against the oldest pending one.
// Directed hues hit the region boundaries and the gray case. Random phases
// then run under a range of settings that includes both extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import hsvrgb_pkg::*;

  // Register indexes that the block must ignore.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Cycles to let the pipeline settle after the last color has arrived.
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned PHASE_COUNT   = 10;
  localparam int unsigned PHASE_HUES    = 55;
  // Percentage of cycles in which each side holds off.
  localparam int unsigned IDLE_PCT      = 28;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Converts hues with its own copy of the settings and keeps the colors
  // still owed by the block, oldest first.
  class rgb_scoreboard;
    logic [7:0] sat;
    logic [7:0] bright;
    rgb_t       owed[$];
    int         errors;

    function new();
      sat    = SATURATION_RESET;
      bright = BRIGHTNESS_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] data);
      case (idx)
        CFG_SATURATION: sat = data;
        CFG_BRIGHTNESS: bright = data;
        default: ;
      endcase
    endfunction

    // Full-width product, then the top byte.
    function logic [7:0] scale(logic [7:0] a, logic [7:0] b);
      logic [15:0] prod;
      prod = a * b;
      return prod[15:8];
    endfunction

    function rgb_t convert(logic [7:0] hue);
      region_t    sector;
      logic [7:0] quot;
      logic [7:0] rem;
      logic [7:0] p;
      logic [7:0] q;
      logic [7:0] t;
      rgb_t       color;
      color = '{bright, bright, bright};
      if (sat != 8'd0) begin
        quot   = hue / REGION_SPAN;
        sector = region_t'(quot[2:0]);
        rem    = (hue - quot * REGION_SPAN) * REM_SCALE;
        p = scale(bright, FULL_SCALE - sat);
        q = scale(bright, FULL_SCALE - scale(sat, rem));
        t = scale(bright, FULL_SCALE - scale(sat, FULL_SCALE - rem));
        case (sector)
          HUE_RED_YEL: color = '{bright, t, p};
          HUE_YEL_GRN: color = '{q, bright, p};
          HUE_GRN_CYN: color = '{p, bright, t};
          HUE_CYN_BLU: color = '{p, q, bright};
          HUE_BLU_MAG: color = '{t, p, bright};
          default:     color = '{bright, p, q};
        endcase
      end
      return color;
    endfunction

    function void note_hue(logic [7:0] hue);
      owed.push_back(convert(hue));
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_rgb(rgb_t got);
      rgb_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected color %0d/%0d/%0d, expected none", $time,
                 got.red, got.green, got.blue);
        errors++;
      end else begin
        want = owed.pop_front();
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [7:0] wr_data;
  bit steady;

  rgb_scoreboard sb;

  hsvrgb_hue_if hue_ch ();
  hsvrgb_rgb_if rgb_ch ();

  hsv_to_rgb_integer_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .hue_ch   (hue_ch),
    .rgb_ch   (rgb_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Output side: random back-pressure, none during the steady stretch.
  always @(posedge clk) begin
    rgb_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watch both channels and feed the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (hue_ch.valid && hue_ch.ready) begin
        sb.note_hue(hue_ch.hue);
      end
      if (rgb_ch.valid && rgb_ch.ready) begin
        sb.check_rgb('{rgb_ch.red, rgb_ch.green, rgb_ch.blue});
      end
    end
  end

  // One register write; the caller lowers the write enable afterwards.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Load both settings, then poke one of the unused indexes.
  task automatic set_config(logic [7:0] sat, logic [7:0] bright);
    write_reg(CFG_SATURATION, sat);
    write_reg(CFG_BRIGHTNESS, bright);
    write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 8'($urandom));
    wr_en <= 1'b0;
  endtask

  // Offer one hue beat, with a random hold-off before it.
  task automatic send_hue(logic [7:0] hue);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        hue_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    hue_ch.valid <= 1'b1;
    hue_ch.hue   <= hue;
    do @(posedge clk); while (!hue_ch.ready);
  endtask

  // Stop sending and wait until every color has come back.
  task automatic drain();
    hue_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hues on either side of each region boundary and at both ends.
  function automatic logic [7:0] boundary_hue();
    case ($urandom_range(11))
      0:  return 8'd0;
      1:  return 8'd42;
      2:  return 8'd43;
      3:  return 8'd85;
      4:  return 8'd86;
      5:  return 8'd128;
      6:  return 8'd129;
      7:  return 8'd171;
      8:  return 8'd172;
      9:  return 8'd214;
      10: return 8'd215;
      default: return 8'd255;
    endcase
  endfunction

  // Settings lean toward the extremes and their neighbors.
  function automatic logic [7:0] pick_setting();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    sb           = new();
    steady       = 1'b0;
    rst          = 1'b1;
    wr_en        = 1'b0;
    wr_index     = '0;
    wr_data      = '0;
    hue_ch.valid = 1'b0;
    hue_ch.hue   = '0;
    rgb_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: every region boundary and the top hue.
    for (int i = 0; i < 12; i++) begin
      send_hue(i == 0 ? 8'd0 : (i == 11 ? 8'd255 : 8'(43 * ((i + 1) / 2) - (i % 2))));
    end
    drain();

    // Zero saturation gives gray.
    set_config(8'd0, 8'd200);
    send_hue(8'd0);
    send_hue(8'd128);
    send_hue(8'd255);
    drain();

    // Full saturation and brightness.
    set_config(8'd255, 8'd255);
    send_hue(8'd0);
    send_hue(8'd42);
    send_hue(8'd43);
    send_hue(8'd255);
    send_hue(8'h55);
    send_hue(8'hAA);
    drain();

    // Black, and the smallest nonzero settings.
    set_config(8'd255, 8'd0);
    send_hue(8'd100);
    send_hue(8'd200);
    drain();
    set_config(8'd1, 8'd1);
    send_hue(8'd30);
    send_hue(8'd250);
    drain();

    // Random phases, each under new settings; one runs with no idling.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      set_config(pick_setting(), pick_setting());
      steady = (ph == 4);
      for (int i = 0; i < PHASE_HUES; i++) begin
        send_hue($urandom_range(7) == 0 ? boundary_hue() : 8'($urandom));
      end
      drain();
      steady = 1'b0;
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[hsv_to_rgb_integer_unit] OK");
    end else begin
      $display("[hsv_to_rgb_integer_unit] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d colors outstanding", $time, sb.pending());
    $display("[hsv_to_rgb_integer_unit] ERROR");
    $finish;
  end

endmodule

/* hsv_to_rgb_integer_unit.f */
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_hue_if.sv
hw/rtl/hsvrgb_rgb_if.sv
hw/rtl/hsvrgb_cfg.sv
hw/rtl/hsvrgb_split.sv
hw/rtl/hsvrgb_prod.sv
hw/rtl/hsv_to_rgb_integer_unit.sv
tb/tb_top.sv
